// File: hdl/btalloc_pkg.sv
// ----------------------------------------------------------------------------
// btalloc_pkg
// Shared types and constants of the boundary-tag first-fit allocator:
// command and status codes, payload widths and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package btalloc_pkg;

  // Payload field widths of the request and response channels.
  localparam int unsigned CMD_W        = 1;
  localparam int unsigned REQ_SIZE_W   = 15;
  localparam int unsigned FREE_ADDR_W  = 14;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned ALLOC_ADDR_W = 14;
  localparam int unsigned BYTES_USED_W = 15;

  // A rounded request size can reach 2**REQ_SIZE_W, so it needs one more bit.
  localparam int unsigned SIZE_W = REQ_SIZE_W + 1;

  // Header plus footer tag, in bytes.
  localparam int unsigned TAG_OVERHEAD = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_NO_CAP = 2'd1,
    STS_NO_FIT = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AWALK,
    ST_AW0,
    ST_AW1,
    ST_AW2,
    ST_AW3,
    ST_FWALK,
    ST_FRIGHT,
    ST_FW0,
    ST_FW1,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: hdl/btalloc_if.sv
// ----------------------------------------------------------------------------
// btalloc_req_if / btalloc_rsp_if
// Valid/ready channels of the allocator: one request item (command, size,
// address to free) and one response item (status, address, bytes in use).
// ----------------------------------------------------------------------------
`default_nettype none

interface btalloc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [btalloc_pkg::CMD_W-1:0]        cmd;
  logic [btalloc_pkg::REQ_SIZE_W-1:0]   req_size;
  logic [btalloc_pkg::FREE_ADDR_W-1:0]  free_addr;

  modport source (output valid, cmd, req_size, free_addr, input ready);
  modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface btalloc_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [btalloc_pkg::STATUS_W-1:0]      status;
  logic [btalloc_pkg::ALLOC_ADDR_W-1:0]  alloc_addr;
  logic [btalloc_pkg::BYTES_USED_W-1:0]  bytes_used;

  modport source (output valid, status, alloc_addr, bytes_used, input ready);
  modport sink   (input valid, status, alloc_addr, bytes_used, output ready);
endinterface

`default_nettype wire

// File: hdl/btalloc_ram.sv
// ----------------------------------------------------------------------------
// btalloc_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module btalloc_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/boundary_tag_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// First-fit allocator over a byte region with header/footer boundary tags,
// block splitting on allocate and coalescing with free neighbors on free.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with one response.
// All tags live in one RAM of MEM_BYTES/4 words with a single read port, and
// the block walks the header chain through that port at one header per
// cycle. A successful allocate inspects the block headers up to the first
// fit, then writes the remainder and used-block tags. When nothing fits, the
// walk covers every header of the region. A rejection for capacity needs no
// walk. A free walks the headers up to the freed one, reads its right
// neighbor unless the freed block ends the region, and writes the merged
// tags. When the walk finds no block in use at the address, no tag is
// written, and a misaligned or zero address needs no walk. The response
// sits in an output register, so a new request is taken while the previous
// response waits.
// No clearing pass is needed after reset: only headers are ever read, and
// every header except the initial one at word 0 is written before it is
// read, so word 0 reads as the full free block until its first write.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_first_fit_allocator #(
  parameter int unsigned MEM_BYTES = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  btalloc_req_if.sink   req_i,
  btalloc_rsp_if.source rsp_o
);

  import btalloc_pkg::*;

  localparam int unsigned TAG_WORDS = MEM_BYTES / 4;
  localparam int unsigned WORD_W    = $clog2(TAG_WORDS);
  localparam int unsigned LEN_W     = $clog2(MEM_BYTES);
  localparam int unsigned TAG_W     = LEN_W + 1;
  localparam int unsigned CNT_W     = $clog2(MEM_BYTES + 1);
  // Common datapath width for lengths, sizes, counts and word indexes.
  localparam int unsigned DW        = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 2;

  localparam logic [DW-1:0]    WORDS_D   = DW'(TAG_WORDS);
  localparam logic [DW-1:0]    MEM_D     = DW'(MEM_BYTES);
  localparam logic [DW-1:0]    OVH_D     = DW'(TAG_OVERHEAD);
  localparam logic [TAG_W-1:0] RESET_TAG = {LEN_W'(MEM_BYTES - TAG_OVERHEAD), 1'b0};

  // Sequencer and datapath registers.
  state_e                  state_q, state_d;
  logic [WORD_W-1:0]       cur_w_q, cur_w_d;
  logic [WORD_W-1:0]       prev_w_q, prev_w_d;
  logic [TAG_W-1:0]        prev_tag_q, prev_tag_d;
  logic                    have_prev_q, have_prev_d;
  logic [DW-1:0]           size_q, size_d;
  logic [DW-1:0]           len_q, len_d;
  logic [WORD_W-1:0]       start_q, start_d;
  logic [DW-1:0]           mlen_q, mlen_d;
  logic [DW-1:0]           target_q, target_d;
  logic [CNT_W-1:0]        used_q, used_d;
  logic                    init_q, init_d;
  logic [WORD_W-1:0]       rd_addr_q, rd_addr_d;
  status_e                 res_status_q, res_status_d;
  logic [ALLOC_ADDR_W-1:0] res_addr_q, res_addr_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [ALLOC_ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [BYTES_USED_W-1:0] out_used_q, out_used_d;

  // Tag RAM ports.
  logic              ram_we;
  logic [WORD_W-1:0] ram_waddr;
  logic [TAG_W-1:0]  ram_wdata;
  logic [WORD_W-1:0] ram_raddr;
  logic [TAG_W-1:0]  ram_rdata;

  // Decoded read data and shared arithmetic.
  logic [TAG_W-1:0] rd_tag;
  logic [DW-1:0]    rd_len;
  logic             rd_used;
  logic [DW-1:0]    cur_d;
  logic [DW-1:0]    nxt;
  logic [DW-1:0]    size_in;
  logic [DW-1:0]    free_cap;
  logic [DW-1:0]    used_sub;

  btalloc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TAG_WORDS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Word 0 reads as the initial free block until it is first written.
  assign rd_tag   = (init_q && (rd_addr_q == '0)) ? RESET_TAG : ram_rdata;
  assign rd_len   = DW'(rd_tag[TAG_W-1:1]);
  assign rd_used  = rd_tag[0];
  assign cur_d    = DW'(cur_w_q);
  assign nxt      = cur_d + (rd_len >> 2) + DW'(2);
  assign size_in  = (DW'(req_i.req_size) + DW'(3)) & ~DW'(3);
  assign free_cap = MEM_D - DW'(used_q);
  assign used_sub = (rd_len <= DW'(used_q)) ? rd_len : DW'(used_q);

  // Handshake outputs.
  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.alloc_addr = out_addr_q;
  assign rsp_o.bytes_used = out_used_q;

  // Next state, RAM accesses and datapath updates.
  always_comb begin
    state_d      = state_q;
    cur_w_d      = cur_w_q;
    prev_w_d     = prev_w_q;
    prev_tag_d   = prev_tag_q;
    have_prev_d  = have_prev_q;
    size_d       = size_q;
    len_d        = len_q;
    start_d      = start_q;
    mlen_d       = mlen_q;
    target_d     = target_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_used_d   = out_used_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_w_q;
    ram_wdata    = '0;
    ram_raddr    = cur_w_q;

    // The response register empties on a transfer.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          res_addr_d = '0;
          if (req_i.cmd == CMD_ALLOC) begin
            size_d = size_in;
            if (free_cap < size_in) begin
              res_status_d = STS_NO_CAP;
              state_d      = ST_DONE;
            end else begin
              cur_w_d   = '0;
              ram_raddr = '0;
              state_d   = ST_AWALK;
            end
          end else begin
            res_status_d = STS_OK;
            target_d     = DW'(req_i.free_addr[FREE_ADDR_W-1:2]);
            if ((req_i.free_addr[1:0] != 2'b00) ||
                (req_i.free_addr[FREE_ADDR_W-1:2] == '0)) begin
              state_d = ST_DONE;
            end else begin
              cur_w_d     = '0;
              have_prev_d = 1'b0;
              ram_raddr   = '0;
              state_d     = ST_FWALK;
            end
          end
        end
      end

      // First-fit walk: one header per cycle.
      ST_AWALK: begin
        if (!rd_used && (rd_len >= size_q + OVH_D)) begin
          len_d   = rd_len;
          state_d = ST_AW0;
        end else if (nxt >= WORDS_D) begin
          res_status_d = STS_NO_FIT;
          state_d      = ST_DONE;
        end else begin
          cur_w_d   = nxt[WORD_W-1:0];
          ram_raddr = nxt[WORD_W-1:0];
        end
      end

      // Split: remainder header and footer, then the used block's tags.
      // Tiling of the region keeps all four indexes inside the RAM.
      ST_AW0: begin
        ram_we    = 1'b1;
        ram_waddr = WORD_W'(cur_d + (size_q >> 2) + DW'(2));
        ram_wdata = {LEN_W'(len_q - size_q - OVH_D), 1'b0};
        state_d   = ST_AW1;
      end

      ST_AW1: begin
        ram_we    = 1'b1;
        ram_waddr = WORD_W'(cur_d + (len_q >> 2) + DW'(1));
        ram_wdata = {LEN_W'(len_q - size_q - OVH_D), 1'b0};
        state_d   = ST_AW2;
      end

      ST_AW2: begin
        ram_we    = 1'b1;
        ram_waddr = cur_w_q;
        ram_wdata = {LEN_W'(size_q), 1'b1};
        state_d   = ST_AW3;
      end

      ST_AW3: begin
        ram_we       = 1'b1;
        ram_waddr    = WORD_W'(cur_d + (size_q >> 2) + DW'(1));
        ram_wdata    = {LEN_W'(size_q), 1'b1};
        used_d       = CNT_W'(DW'(used_q) + size_q);
        res_status_d = STS_OK;
        res_addr_d   = ALLOC_ADDR_W'((cur_d + DW'(1)) << 2);
        state_d      = ST_DONE;
      end

      // Walk to the block being freed, keeping the previous header.
      ST_FWALK: begin
        if ((cur_d + DW'(1)) == target_q) begin
          if (!rd_used) begin
            state_d = ST_DONE;
          end else begin
            used_d = CNT_W'(DW'(used_q) - used_sub);
            if (have_prev_q && !prev_tag_q[0]) begin
              start_d = prev_w_q;
              mlen_d  = rd_len + DW'(prev_tag_q[TAG_W-1:1]) + OVH_D;
            end else begin
              start_d = cur_w_q;
              mlen_d  = rd_len;
            end
            // The right neighbor header follows the freed block directly.
            if (nxt < WORDS_D) begin
              ram_raddr = nxt[WORD_W-1:0];
              state_d   = ST_FRIGHT;
            end else begin
              state_d = ST_FW0;
            end
          end
        end else if ((cur_d + DW'(1)) > target_q) begin
          state_d = ST_DONE;
        end else begin
          prev_w_d    = cur_w_q;
          prev_tag_d  = rd_tag;
          have_prev_d = 1'b1;
          if (nxt >= WORDS_D) begin
            state_d = ST_DONE;
          end else begin
            cur_w_d   = nxt[WORD_W-1:0];
            ram_raddr = nxt[WORD_W-1:0];
          end
        end
      end

      // Merge with a free right neighbor.
      ST_FRIGHT: begin
        if (!rd_used) begin
          mlen_d = mlen_q + rd_len + OVH_D;
        end
        state_d = ST_FW0;
      end

      ST_FW0: begin
        ram_we    = 1'b1;
        ram_waddr = start_q;
        ram_wdata = {LEN_W'(mlen_q), 1'b0};
        state_d   = ST_FW1;
      end

      ST_FW1: begin
        ram_we    = 1'b1;
        ram_waddr = WORD_W'(DW'(start_q) + (mlen_q >> 2) + DW'(1));
        ram_wdata = {LEN_W'(mlen_q), 1'b0};
        state_d   = ST_DONE;
      end

      // Hand the result to the response register once it is free.
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_used_d   = BYTES_USED_W'(used_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Word 0 keeps its reset reading until the first write to it.
  assign init_d    = (ram_we && (ram_waddr == '0)) ? 1'b0 : init_q;
  assign rd_addr_d = ram_raddr;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cur_w_q      <= cur_w_d;
    prev_w_q     <= prev_w_d;
    prev_tag_q   <= prev_tag_d;
    have_prev_q  <= have_prev_d;
    size_q       <= size_d;
    len_q        <= len_d;
    start_q      <= start_d;
    mlen_q       <= mlen_d;
    target_q     <= target_d;
    rd_addr_q    <= rd_addr_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_used_q   <= out_used_d;
  end

  // The byte count never exceeds the region.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(used_q) <= MEM_D)
    else $error("bytes in use exceed the region");

  // A failed allocate reports address zero.
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && ((rsp_o.status == STS_NO_CAP) || (rsp_o.status == STS_NO_FIT)))
      |-> (rsp_o.alloc_addr == '0))
    else $error("failed allocate with nonzero address");

  // Tag writes happen only in the write-back states.
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_AW0) || (state_q == ST_AW1) || (state_q == ST_AW2) ||
                (state_q == ST_AW3) || (state_q == ST_FW0) || (state_q == ST_FW1)))
    else $error("tag write outside write-back");

  // An accepted request always leaves the idle state.
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE))
    else $error("request transfer without leaving idle");

  // Once word 0 has been written, its reset reading never returns.
  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |=> !init_q)
    else $error("word 0 reset reading came back");

endmodule

`default_nettype wire
